// File: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define PPD_ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppd_checker: assertion failed");

// Same, on the block clock and reset.
`define PPD_ASSERT(lbl, prop) `PPD_ASSERT_AT(lbl, aclk, aresetn, prop)

`endif

// File: rtl/ppd_pkg.sv
// Field widths shared by the period detector and its checker.
package ppd_pkg;

    localparam int CH_W   = 8;
    localparam int PLEN_W = 13;
    localparam int BORD_W = 12;
    localparam int REP_W  = 13;

endpackage

// File: rtl/ppd_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module ppd_divider #(
    parameter int W = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/prefix_period_detector.sv
// Online KMP border table builder with period detection, top level.
//
//  channel | direction | ports                                          | accepted when
//  s_      | in        | s_ch, s_first                                  | s_valid && s_ready
//  m_      | out       | m_prefix_len, m_border_len, m_periodic,        | m_valid && m_ready
//          |           | m_repeats, m_overflow                          |
//
// Per item: overflow goes to the output load; otherwise a char/border memory read,
// then a compare per failure-chain step, the table write, a restoring divider run
// when the border is nonzero (LW = clog2(MAX_LEN+1) bits), then the output load.
// s_ready is high only while idle; a result waiting on m_ready holds the next one.
// Synchronous active-low reset clears control state; stores need no clearing pass.
module prefix_period_detector #(
    parameter int MAX_LEN = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ppd_pkg::CH_W-1:0]    s_ch,
    input  logic                        s_first,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ppd_pkg::PLEN_W-1:0]  m_prefix_len,
    output logic [ppd_pkg::BORD_W-1:0]  m_border_len,
    output logic                        m_periodic,
    output logic [ppd_pkg::REP_W-1:0]   m_repeats,
    output logic                        m_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_WRITE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [ppd_pkg::CH_W-1:0] c_reg, c_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [AW-1:0]            k_reg, k_next;
    logic [LW-1:0]            cur_len_reg, cur_len_next;
    logic [AW-1:0]            cur_border_reg, cur_border_next;
    logic [LW-1:0]            res_len_reg, res_len_next;
    logic [AW-1:0]            res_border_reg, res_border_next;
    logic                     res_per_reg, res_per_next;
    logic [LW-1:0]            res_rep_reg, res_rep_next;
    logic                     res_ovf_reg, res_ovf_next;

    logic                       m_valid_reg, m_valid_next;
    logic [ppd_pkg::PLEN_W-1:0] m_plen_reg, m_plen_next;
    logic [ppd_pkg::BORD_W-1:0] m_bord_reg, m_bord_next;
    logic                       m_per_reg, m_per_next;
    logic [ppd_pkg::REP_W-1:0]  m_rep_reg, m_rep_next;
    logic                       m_ovf_reg, m_ovf_next;

    logic [ppd_pkg::CH_W-1:0] char_mem [MAX_LEN];
    logic [AW-1:0]            bt_mem   [MAX_LEN];
    logic [ppd_pkg::CH_W-1:0] ch_rd_reg;
    logic [AW-1:0]            bt_rd_reg;

    logic [LW-1:0] eff_len;
    logic [AW-1:0] eff_border;
    logic [LW-1:0] len_w;
    logic [LW-1:0] period;
    logic          div_start;
    logic          div_done;
    logic [LW-1:0] div_quo;
    logic [LW-1:0] div_rem;

    logic [LW+ppd_pkg::PLEN_W-1:0] plen_ext;
    logic [AW+ppd_pkg::BORD_W-1:0] bord_ext;
    logic [LW+ppd_pkg::REP_W-1:0]  rep_ext;

    assign eff_len    = s_first ? '0 : cur_len_reg;
    assign eff_border = s_first ? '0 : cur_border_reg;
    assign len_w      = LW'(pos_reg) + LW'(1);
    assign period     = len_w - LW'(k_reg);
    assign div_start  = (state_reg == ST_WRITE) && (k_reg != '0);

    assign plen_ext = {{ppd_pkg::PLEN_W{1'b0}}, res_len_reg};
    assign bord_ext = {{ppd_pkg::BORD_W{1'b0}}, res_border_reg};
    assign rep_ext  = {{ppd_pkg::REP_W{1'b0}}, res_rep_reg};

    ppd_divider #(
        .W (LW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (len_w),
        .divisor   (period),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            ch_rd_reg <= char_mem[k_reg];
            bt_rd_reg <= bt_mem[k_reg - 1'b1];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            char_mem[pos_reg] <= c_reg;
            bt_mem[pos_reg]   <= k_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        c_next          = c_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        cur_len_next    = cur_len_reg;
        cur_border_next = cur_border_reg;
        res_len_next    = res_len_reg;
        res_border_next = res_border_reg;
        res_per_next    = res_per_reg;
        res_rep_next    = res_rep_reg;
        res_ovf_next    = res_ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_plen_next     = m_plen_reg;
        m_bord_next     = m_bord_reg;
        m_per_next      = m_per_reg;
        m_rep_next      = m_rep_reg;
        m_ovf_next      = m_ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (eff_len == MAX_LEN_L) begin
                        res_len_next    = cur_len_reg;
                        res_border_next = cur_border_reg;
                        res_per_next    = 1'b0;
                        res_rep_next    = '0;
                        res_ovf_next    = 1'b1;
                        state_next      = ST_DONE;
                    end else begin
                        c_next     = s_ch;
                        pos_next   = eff_len[AW-1:0];
                        k_next     = eff_border;
                        state_next = (eff_len == '0) ? ST_WRITE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (ch_rd_reg == c_reg) begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_WRITE;
                end else if (k_reg == '0) begin
                    state_next = ST_WRITE;
                end else begin
                    k_next     = bt_rd_reg;
                    state_next = ST_FETCH;
                end
            end
            ST_WRITE: begin
                cur_len_next    = len_w;
                cur_border_next = k_reg;
                res_len_next    = len_w;
                res_border_next = k_reg;
                res_per_next    = 1'b0;
                res_rep_next    = '0;
                res_ovf_next    = 1'b0;
                state_next      = (k_reg != '0) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        res_per_next = 1'b1;
                        res_rep_next = div_quo;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_plen_next  = plen_ext[ppd_pkg::PLEN_W-1:0];
                    m_bord_next  = bord_ext[ppd_pkg::BORD_W-1:0];
                    m_per_next   = res_per_reg;
                    m_rep_next   = rep_ext[ppd_pkg::REP_W-1:0];
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_len_reg    <= '0;
            cur_border_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_len_reg    <= cur_len_next;
            cur_border_reg <= cur_border_next;
            m_valid_reg    <= m_valid_next;
        end
        c_reg          <= c_next;
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        res_len_reg    <= res_len_next;
        res_border_reg <= res_border_next;
        res_per_reg    <= res_per_next;
        res_rep_reg    <= res_rep_next;
        res_ovf_reg    <= res_ovf_next;
        m_plen_reg     <= m_plen_next;
        m_bord_reg     <= m_bord_next;
        m_per_reg      <= m_per_next;
        m_rep_reg      <= m_rep_next;
        m_ovf_reg      <= m_ovf_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_prefix_len = m_plen_reg;
    assign m_border_len = m_bord_reg;
    assign m_periodic   = m_per_reg;
    assign m_repeats    = m_rep_reg;
    assign m_overflow   = m_ovf_reg;

endmodule

// File: rtl/ppd_checker.sv
// Port-level assertions for the period detector, bound to the top level.
`include "assert_macros.svh"

module ppd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ppd_pkg::PLEN_W-1:0]  m_prefix_len,
    input logic [ppd_pkg::BORD_W-1:0]  m_border_len,
    input logic                        m_periodic,
    input logic [ppd_pkg::REP_W-1:0]   m_repeats,
    input logic                        m_overflow
);

    logic [ppd_pkg::PLEN_W+ppd_pkg::BORD_W+ppd_pkg::REP_W+1:0] m_payload;

    assign m_payload = {m_prefix_len, m_border_len, m_periodic, m_repeats, m_overflow};

    // one item in flight at a time
    `PPD_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready)
    `PPD_ASSERT(a_result_holds, (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
    `PPD_ASSERT(a_periodic_not_overflow, (m_valid && m_periodic) |-> !m_overflow)
    `PPD_ASSERT(a_repeats_zero, (m_valid && !m_periodic) |-> (m_repeats == '0))

endmodule

bind prefix_period_detector ppd_checker u_ppd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_prefix_len (m_prefix_len),
    .m_border_len (m_border_len),
    .m_periodic   (m_periodic),
    .m_repeats    (m_repeats),
    .m_overflow   (m_overflow)
);
